/* rtl/core/cesel_pkg.sv */
// Shared types, constants and helper functions for the column encoding selector.
`default_nettype none
package cesel_pkg;

    localparam int COUNT_BITS = 32;
    localparam int VALUE_BITS = 64;
    localparam int OUT_CNT_BITS = 32;
    localparam int LEN_BITS = 7;
    localparam int DIST_BITS = 32;

    localparam logic [LEN_BITS-1:0] SOURCE_BITS_RESET = LEN_BITS'(64);
    localparam logic [LEN_BITS-1:0] NO_VALID_RANGE = LEN_BITS'(64);

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [VALUE_BITS-1:0] t_value;

    typedef enum logic [2:0] {
        ENC_PLAIN  = 3'd0,
        ENC_RLE    = 3'd1,
        ENC_DELTA  = 3'd2,
        ENC_BITPACK = 3'd3,
        ENC_DICT   = 3'd4
    } t_enc;

    typedef struct packed {
        t_count                 row_count;
        t_count                 null_rows;
        t_count                 run_count;
        t_value                 value_min;
        t_value                 value_max;
        logic                   any_valid;
        t_value                 delta_min;
        t_value                 delta_max;
        logic                   mono;
        logic [DIST_BITS-1:0]   distinct;
    } t_snap;

    function automatic t_count sat_inc(input t_count c);
        return (c == '1) ? c : c + t_count'(1);
    endfunction

    function automatic logic [OUT_CNT_BITS-1:0] out_sat(input t_count c);
        logic [127:0] wide;
        wide = 128'(c);
        return (wide > 128'(OUT_CNT_BITS'('1))) ? '1 : wide[OUT_CNT_BITS-1:0];
    endfunction

    function automatic logic [LEN_BITS-1:0] bit_length(input t_value x);
        logic [LEN_BITS-1:0] n;
        n = '0;
        for (int i = 0; i < VALUE_BITS; i++) begin
            if (x[i]) n = LEN_BITS'(i + 1);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/column_encoding_selector.sv */
// Top level of the column encoding selector: source width register and stage wiring.
// Throughput: one row per cycle, back to back, unless o_stall holds the input.
// The result reaches o_valid after the last row passes the row input register,
// the snapshot register (profile update) and the result register.
// Reset clears the profile (monotonic flag set) and sets source_bits to 64.
`default_nettype none
module column_encoding_selector (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic [cesel_pkg::VALUE_BITS-1:0]       i_value,
    input  wire logic                                   i_valid_req,
    input  wire logic                                   i_last,
    input  wire logic [cesel_pkg::DIST_BITS-1:0]        i_distinct_estimate,
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [cesel_pkg::LEN_BITS-1:0]         i_cfg_wr_data,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic [2:0]                                  o_encoding,
    output logic [cesel_pkg::OUT_CNT_BITS-1:0]          o_row_total,
    output logic [cesel_pkg::OUT_CNT_BITS-1:0]          o_null_total,
    output logic [cesel_pkg::OUT_CNT_BITS-1:0]          o_run_total,
    output logic [cesel_pkg::LEN_BITS-1:0]              o_range_bits,
    output logic [cesel_pkg::LEN_BITS-1:0]              o_delta_span_bits,
    output logic                                        o_is_monotonic,
    output logic [cesel_pkg::VALUE_BITS-1:0]            o_value_min,
    output logic [cesel_pkg::VALUE_BITS-1:0]            o_value_max
);

    logic [cesel_pkg::LEN_BITS-1:0] r_source_bits;
    logic                           w_snap_valid;
    logic                           w_snap_ready;
    cesel_pkg::t_snap               w_snap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_bits <= cesel_pkg::SOURCE_BITS_RESET;
        end else if (i_cfg_wr_en) begin
            r_source_bits <= i_cfg_wr_data;
        end
    end

    cesel_profile u_profile (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_value             (i_value),
        .i_valid_req         (i_valid_req),
        .i_last              (i_last),
        .i_distinct_estimate (i_distinct_estimate),
        .i_snap_ready        (w_snap_ready),
        .o_snap_valid        (w_snap_valid),
        .o_snap              (w_snap)
    );

    cesel_finish u_finish (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_source_bits     (r_source_bits),
        .i_snap_valid      (w_snap_valid),
        .o_snap_ready      (w_snap_ready),
        .i_snap            (w_snap),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_encoding        (o_encoding),
        .o_row_total       (o_row_total),
        .o_null_total      (o_null_total),
        .o_run_total       (o_run_total),
        .o_range_bits      (o_range_bits),
        .o_delta_span_bits (o_delta_span_bits),
        .o_is_monotonic    (o_is_monotonic),
        .o_value_min       (o_value_min),
        .o_value_max       (o_value_max)
    );

endmodule
`default_nettype wire

/* rtl/core/cesel_profile.sv */
// Row input register, running column profile and end-of-column snapshot register.
`default_nettype none
module cesel_profile (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [cesel_pkg::VALUE_BITS-1:0]   i_value,
    input  wire logic                               i_valid_req,
    input  wire logic                               i_last,
    input  wire logic [cesel_pkg::DIST_BITS-1:0]    i_distinct_estimate,
    input  wire logic                               i_snap_ready,
    output logic                                    o_snap_valid,
    output cesel_pkg::t_snap                        o_snap
);

    logic                               r_in_valid;
    cesel_pkg::t_value                  r_in_value;
    logic                               r_in_vreq;
    logic                               r_in_last;
    logic [cesel_pkg::DIST_BITS-1:0]    r_in_dist;

    cesel_pkg::t_value  r_prev, n_prev;
    cesel_pkg::t_count  r_rows, n_rows;
    cesel_pkg::t_count  r_nulls, n_nulls;
    cesel_pkg::t_count  r_runs, n_runs;
    cesel_pkg::t_value  r_vmin, n_vmin;
    cesel_pkg::t_value  r_vmax, n_vmax;
    logic               r_any, n_any;
    cesel_pkg::t_value  r_dmin, n_dmin;
    cesel_pkg::t_value  r_dmax, n_dmax;
    logic               r_mono, n_mono;

    logic               r_snap_valid;
    cesel_pkg::t_snap   r_snap;

    logic               w_snap_ready;
    logic               w_go;
    logic               w_in_ready;
    cesel_pkg::t_value  w_v;
    cesel_pkg::t_value  w_d;
    logic               w_first;
    logic               w_second;

    assign w_snap_ready = !r_snap_valid || i_snap_ready;
    assign w_go = r_in_valid && (!r_in_last || w_snap_ready);
    assign w_in_ready = !r_in_valid || w_go;
    assign o_stall = !w_in_ready;

    assign w_v = r_in_vreq ? r_in_value : r_prev;
    assign w_d = w_v - r_prev;
    assign w_first = (r_rows == '0);
    assign w_second = (r_rows == cesel_pkg::COUNT_BITS'(1));

    always_comb begin
        n_prev  = w_v;
        n_rows  = cesel_pkg::sat_inc(r_rows);
        n_nulls = r_in_vreq ? r_nulls : cesel_pkg::sat_inc(r_nulls);
        n_runs  = (w_first || (w_v != r_prev)) ? cesel_pkg::sat_inc(r_runs) : r_runs;
        n_vmin  = r_vmin;
        n_vmax  = r_vmax;
        n_any   = r_any || r_in_vreq;
        n_dmin  = r_dmin;
        n_dmax  = r_dmax;
        n_mono  = r_mono;
        if (r_in_vreq) begin
            if (!r_any) begin
                n_vmin = w_v;
                n_vmax = w_v;
            end else begin
                if ($signed(w_v) < $signed(r_vmin)) n_vmin = w_v;
                if ($signed(r_vmax) < $signed(w_v)) n_vmax = w_v;
            end
        end
        if (!w_first) begin
            if (w_d[cesel_pkg::VALUE_BITS-1]) n_mono = 1'b0;
            if (w_second) begin
                n_dmin = w_d;
                n_dmax = w_d;
            end else begin
                if ($signed(w_d) < $signed(r_dmin)) n_dmin = w_d;
                if ($signed(r_dmax) < $signed(w_d)) n_dmax = w_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_snap_valid <= 1'b0;
            r_prev       <= '0;
            r_rows       <= '0;
            r_nulls      <= '0;
            r_runs       <= '0;
            r_vmin       <= '0;
            r_vmax       <= '0;
            r_any        <= 1'b0;
            r_dmin       <= '0;
            r_dmax       <= '0;
            r_mono       <= 1'b1;
        end else begin
            if (w_in_ready) r_in_valid <= i_valid;
            if (w_snap_ready) r_snap_valid <= w_go && r_in_last;
            if (w_go) begin
                if (r_in_last) begin
                    r_prev  <= '0;
                    r_rows  <= '0;
                    r_nulls <= '0;
                    r_runs  <= '0;
                    r_vmin  <= '0;
                    r_vmax  <= '0;
                    r_any   <= 1'b0;
                    r_dmin  <= '0;
                    r_dmax  <= '0;
                    r_mono  <= 1'b1;
                end else begin
                    r_prev  <= n_prev;
                    r_rows  <= n_rows;
                    r_nulls <= n_nulls;
                    r_runs  <= n_runs;
                    r_vmin  <= n_vmin;
                    r_vmax  <= n_vmax;
                    r_any   <= n_any;
                    r_dmin  <= n_dmin;
                    r_dmax  <= n_dmax;
                    r_mono  <= n_mono;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_valid) begin
            r_in_value <= i_value;
            r_in_vreq  <= i_valid_req;
            r_in_last  <= i_last;
            r_in_dist  <= i_distinct_estimate;
        end
        if (w_go && r_in_last) begin
            r_snap.row_count  <= n_rows;
            r_snap.null_rows  <= n_nulls;
            r_snap.run_count  <= n_runs;
            r_snap.value_min  <= n_vmin;
            r_snap.value_max  <= n_vmax;
            r_snap.any_valid  <= n_any;
            r_snap.delta_min  <= n_dmin;
            r_snap.delta_max  <= n_dmax;
            r_snap.mono       <= n_mono;
            r_snap.distinct   <= r_in_dist;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap = r_snap;

endmodule
`default_nettype wire

/* rtl/core/cesel_finish.sv */
// Encoding decision and registered result output.
`default_nettype none
module cesel_finish (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic [cesel_pkg::LEN_BITS-1:0]         i_source_bits,
    input  wire logic                                   i_snap_valid,
    output logic                                        o_snap_ready,
    input  wire cesel_pkg::t_snap                       i_snap,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic [2:0]                                  o_encoding,
    output logic [cesel_pkg::OUT_CNT_BITS-1:0]          o_row_total,
    output logic [cesel_pkg::OUT_CNT_BITS-1:0]          o_null_total,
    output logic [cesel_pkg::OUT_CNT_BITS-1:0]          o_run_total,
    output logic [cesel_pkg::LEN_BITS-1:0]              o_range_bits,
    output logic [cesel_pkg::LEN_BITS-1:0]              o_delta_span_bits,
    output logic                                        o_is_monotonic,
    output logic [cesel_pkg::VALUE_BITS-1:0]            o_value_min,
    output logic [cesel_pkg::VALUE_BITS-1:0]            o_value_max
);

    localparam int CW = cesel_pkg::COUNT_BITS + 3;
    localparam int DW = cesel_pkg::DIST_BITS + 5;
    localparam int MW = (CW > DW) ? CW : DW;

    logic                               r_valid;
    logic                               w_ready;
    logic                               w_many;
    logic                               w_mono;
    logic [cesel_pkg::LEN_BITS-1:0]     w_range;
    logic [cesel_pkg::LEN_BITS-1:0]     w_span;
    logic [MW-1:0]                      w_rows;
    logic [MW-1:0]                      w_runs4;
    logic [MW-1:0]                      w_dist20;
    cesel_pkg::t_enc                    w_enc;

    assign w_ready = !r_valid || !i_stall;
    assign o_snap_ready = w_ready;

    assign w_many = (i_snap.row_count > cesel_pkg::COUNT_BITS'(1));
    assign w_mono = i_snap.mono && w_many;
    assign w_range = i_snap.any_valid
        ? cesel_pkg::bit_length(i_snap.value_max - i_snap.value_min)
        : cesel_pkg::NO_VALID_RANGE;
    assign w_span = w_many
        ? cesel_pkg::bit_length(i_snap.delta_max - i_snap.delta_min)
        : '0;

    assign w_rows = MW'(i_snap.row_count);
    assign w_runs4 = MW'(i_snap.run_count) << 2;
    assign w_dist20 = (MW'(i_snap.distinct) << 4) + (MW'(i_snap.distinct) << 2);

    always_comb begin
        if (w_rows >= w_runs4) begin
            w_enc = cesel_pkg::ENC_RLE;
        end else if (w_mono && (w_span < w_range) && (w_span < i_source_bits)) begin
            w_enc = cesel_pkg::ENC_DELTA;
        end else if (w_range < i_source_bits) begin
            w_enc = cesel_pkg::ENC_BITPACK;
        end else if (w_dist20 < w_rows) begin
            w_enc = cesel_pkg::ENC_DICT;
        end else begin
            w_enc = cesel_pkg::ENC_PLAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_snap_valid) begin
            o_encoding        <= w_enc;
            o_row_total       <= cesel_pkg::out_sat(i_snap.row_count);
            o_null_total      <= cesel_pkg::out_sat(i_snap.null_rows);
            o_run_total       <= cesel_pkg::out_sat(i_snap.run_count);
            o_range_bits      <= w_range;
            o_delta_span_bits <= w_span;
            o_is_monotonic    <= w_mono;
            o_value_min       <= i_snap.value_min;
            o_value_max       <= i_snap.value_max;
        end
    end

    assign o_valid = r_valid;

endmodule
`default_nettype wire

/* verif/column_encoding_selector_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the column encoding selector: directed and random columns against a profile predictor.
module column_encoding_selector_test;

    localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_AT = 700;
    localparam int HOLD_LEN = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [63:0] value;
        logic        valid_req;
        logic        last;
        logic [31:0] distinct;
    } t_col_row;

    typedef struct packed {
        cesel_pkg::t_enc encoding;
        logic [31:0]     rows;
        logic [31:0]     nulls;
        logic [31:0]     runs;
        logic [6:0]      range_bits;
        logic [6:0]      span_bits;
        logic            mono;
        logic [63:0]     lo;
        logic [63:0]     hi;
    } t_profile;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_value = '0;
    logic        i_valid_req = 1'b0;
    logic        i_last = 1'b0;
    logic [31:0] i_distinct_estimate = '0;
    logic        i_cfg_wr_en = 1'b0;
    logic [6:0]  i_cfg_wr_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_encoding;
    logic [31:0] o_row_total;
    logic [31:0] o_null_total;
    logic [31:0] o_run_total;
    logic [6:0]  o_range_bits;
    logic [6:0]  o_delta_span_bits;
    logic        o_is_monotonic;
    logic [63:0] o_value_min;
    logic [63:0] o_value_max;

    column_encoding_selector u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_value             (i_value),
        .i_valid_req         (i_valid_req),
        .i_last              (i_last),
        .i_distinct_estimate (i_distinct_estimate),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_encoding          (o_encoding),
        .o_row_total         (o_row_total),
        .o_null_total        (o_null_total),
        .o_run_total         (o_run_total),
        .o_range_bits        (o_range_bits),
        .o_delta_span_bits   (o_delta_span_bits),
        .o_is_monotonic      (o_is_monotonic),
        .o_value_min         (o_value_min),
        .o_value_max         (o_value_max)
    );

    // predictor state
    logic [6:0]  cfg_width = 7'd64;
    logic [63:0] prev_val;
    logic [31:0] rows, nulls, runs;
    logic [63:0] lo_val, hi_val, lo_delta, hi_delta;
    logic        seen_valid, rising;

    t_col_row pending_rows[$];
    t_profile profile_q[$];
    t_col_row cur_row;
    int rows_queued = 0;
    int rows_accepted = 0;
    int mismatches = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 0;
    bit calm = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [6:0] bit_len(input logic [63:0] x);
        logic [6:0] n;
        n = '0;
        while (x != 0) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    function automatic void clear_profile();
        prev_val = '0;
        rows = '0;
        nulls = '0;
        runs = '0;
        lo_val = '0;
        hi_val = '0;
        seen_valid = 1'b0;
        lo_delta = '0;
        hi_delta = '0;
        rising = 1'b1;
    endfunction

    function automatic void account_row(input t_col_row r);
        logic [63:0] v, d;
        logic first, second;
        t_profile p;
        v = r.valid_req ? r.value : prev_val;
        first = (rows == 0);
        second = (rows == 1);
        if (r.valid_req) begin
            if (!seen_valid) begin
                lo_val = v;
                hi_val = v;
            end else begin
                if ($signed(v) < $signed(lo_val)) lo_val = v;
                if ($signed(hi_val) < $signed(v)) hi_val = v;
            end
            seen_valid = 1'b1;
        end else begin
            nulls = bump(nulls);
        end
        if (first || v != prev_val) runs = bump(runs);
        if (!first) begin
            d = v - prev_val;
            if (d[63]) rising = 1'b0;
            if (second) begin
                lo_delta = d;
                hi_delta = d;
            end else begin
                if ($signed(d) < $signed(lo_delta)) lo_delta = d;
                if ($signed(hi_delta) < $signed(d)) hi_delta = d;
            end
        end
        prev_val = v;
        rows = bump(rows);
        if (!r.last) return;

        p.range_bits = seen_valid ? bit_len(hi_val - lo_val) : 7'd64;
        p.span_bits = (rows > 1) ? bit_len(hi_delta - lo_delta) : 7'd0;
        p.mono = rising && (rows > 1);
        if (64'(rows) >= 64'(runs) * 64'd4)
            p.encoding = cesel_pkg::ENC_RLE;
        else if (p.mono && p.span_bits < p.range_bits && p.span_bits < cfg_width)
            p.encoding = cesel_pkg::ENC_DELTA;
        else if (p.range_bits < cfg_width)
            p.encoding = cesel_pkg::ENC_BITPACK;
        else if (64'(r.distinct) * 64'd20 < 64'(rows))
            p.encoding = cesel_pkg::ENC_DICT;
        else
            p.encoding = cesel_pkg::ENC_PLAIN;
        p.rows = rows;
        p.nulls = nulls;
        p.runs = runs;
        p.lo = lo_val;
        p.hi = hi_val;
        profile_q.push_back(p);
        clear_profile();
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_profile();
        t_profile got, want;
        got.encoding = cesel_pkg::t_enc'(o_encoding);
        got.rows = o_row_total;
        got.nulls = o_null_total;
        got.runs = o_run_total;
        got.range_bits = o_range_bits;
        got.span_bits = o_delta_span_bits;
        got.mono = o_is_monotonic;
        got.lo = o_value_min;
        got.hi = o_value_max;
        if (profile_q.size() == 0) begin
            report_mismatch("unexpected profile, encoding", 64'(got.encoding), '0);
            return;
        end
        want = profile_q.pop_front();
        if (got.encoding != want.encoding)
            report_mismatch("encoding", 64'(got.encoding), 64'(want.encoding));
        if (got.rows != want.rows) report_mismatch("row_total", 64'(got.rows), 64'(want.rows));
        if (got.nulls != want.nulls)
            report_mismatch("null_total", 64'(got.nulls), 64'(want.nulls));
        if (got.runs != want.runs) report_mismatch("run_total", 64'(got.runs), 64'(want.runs));
        if (got.range_bits != want.range_bits)
            report_mismatch("range_bits", 64'(got.range_bits), 64'(want.range_bits));
        if (got.span_bits != want.span_bits)
            report_mismatch("delta_span_bits", 64'(got.span_bits), 64'(want.span_bits));
        if (got.mono != want.mono)
            report_mismatch("is_monotonic", 64'(got.mono), 64'(want.mono));
        if (got.lo != want.lo) report_mismatch("value_min", got.lo, want.lo);
        if (got.hi != want.hi) report_mismatch("value_max", got.hi, want.hi);
    endtask

    // row driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                account_row(cur_row);
                rows_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_rows.size() > 0) begin
                    cur_row = pending_rows.pop_front();
                    i_value <= cur_row.value;
                    i_valid_req <= cur_row.valid_req;
                    i_last <= cur_row.last;
                    i_distinct_estimate <= cur_row.distinct;
                    i_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 5);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_profile();
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && rows_accepted >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_LEN - 1;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic push_row(input logic [63:0] v, input logic vr, input logic lst,
                            input logic [31:0] est);
        t_col_row r;
        r.value = v;
        r.valid_req = vr;
        r.last = lst;
        r.distinct = est;
        pending_rows.push_back(r);
        rows_queued++;
    endtask

    task automatic queue_random_column();
        int len, style, null_odds, run_left, k;
        logic [63:0] v, base, step, mask;
        logic [31:0] row_est;
        logic vr;
        k = $urandom_range(0, 19);
        if (k < 13) len = $urandom_range(1, 4);
        else if (k < 19) len = $urandom_range(5, 20);
        else len = $urandom_range(21, 60);
        style = $urandom_range(0, 4);
        case ($urandom_range(0, 7))
            0, 1, 2, 3: null_odds = 0;
            4, 5: null_odds = 8;
            6: null_odds = 2;
            default: null_odds = 1;
        endcase
        base = rand64();
        mask = 64'hFFFF_FFFF_FFFF_FFFF >> $urandom_range(0, 64);
        step = rand64() & (64'hFFFF_FFFF_FFFF_FFFF >> $urandom_range(58, 64));
        v = base;
        run_left = 0;
        for (int i = 0; i < len; i++) begin
            case (style)
                0: begin
                    if (run_left == 0) begin
                        v = base + 64'($urandom_range(0, 3));
                        run_left = $urandom_range(1, 6);
                    end
                    run_left--;
                end
                1: v = base + step * 64'(i);
                2: v = base + (rand64() & mask);
                3: v = rand64();
                default: begin
                    case ($urandom_range(0, 4))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2: v = '0;
                        3: v = '1;
                        default: v = 64'd1;
                    endcase
                end
            endcase
            if (null_odds == 0) vr = 1'b1;
            else if (null_odds == 1) vr = 1'b0;
            else vr = ($urandom_range(1, null_odds) != 1);
            if (i == len - 1) begin
                case ($urandom_range(0, 3))
                    0: row_est = $urandom_range(0, 3);
                    1: row_est = $urandom;
                    2: row_est = 32'(len / 20);
                    default: row_est = '1;
                endcase
            end else begin
                row_est = $urandom;
            end
            push_row(vr ? v : rand64(), vr, i == len - 1, row_est);
        end
    endtask

    task automatic settle();
        while (rows_accepted != rows_queued || profile_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_source_bits(input logic [6:0] w);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_width = w;
    endtask

    initial begin
        logic [6:0] widths[7];
        int target;
        widths = '{7'd8, 7'd32, 7'd127, 7'd16, 7'd0, 7'd100, 7'd64};
        clear_profile();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed columns at the reset width
        push_row(VAL_MAX, 1, 1, 32'd0);
        push_row(64'h1234, 0, 1, 32'hFFFF_FFFF);
        // null first, then a value, then null
        push_row(rand64(), 0, 0, 32'hA5A5_A5A5);
        push_row(64'd9, 1, 0, 32'h5A5A_5A5A);
        push_row(rand64(), 0, 1, 32'd1);
        // difference wraps both ways
        push_row(VAL_MIN, 1, 0, 32'd7);
        push_row(VAL_MAX, 1, 0, 32'd7);
        push_row(VAL_MIN, 1, 1, 32'd0);
        // run-length
        for (int i = 0; i < 4; i++) push_row(64'd5, 1, i == 3, 32'd3);
        // delta
        for (int i = 0; i < 5; i++) push_row(64'(i * 10), 1, i == 4, 32'hFFFF_FFFF);
        // bit-pack
        push_row(64'd3, 1, 0, 32'd0);
        push_row(-64'sd2, 1, 0, 32'd0);
        push_row(64'd7, 1, 0, 32'd0);
        push_row(64'd1, 1, 1, 32'hFFFF_FFFF);
        // dictionary, then plain
        push_row(VAL_MIN, 1, 0, 32'd0);
        push_row(VAL_MAX, 1, 0, 32'd0);
        push_row(64'd0, 1, 0, 32'd0);
        push_row(64'd1, 1, 1, 32'd0);
        push_row(VAL_MIN, 1, 0, 32'd0);
        push_row(VAL_MAX, 1, 0, 32'd0);
        push_row(64'd0, 1, 0, 32'd0);
        push_row(64'd1, 1, 1, 32'hFFFF_FFFF);

        for (int p = 0; p < 7; p++) begin
            settle();
            write_source_bits(widths[p]);
            if (p == 6) calm = 1;
            target = rows_queued + 270;
            while (rows_queued < target) queue_random_column();
        end
        settle();

        if (profile_q.size() != 0)
            report_mismatch("profiles never delivered", 64'(profile_q.size()), '0);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
